FILE: sv/vrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the voxel ray traversal block.
// Depends on nothing.
package vrt_pkg;

    localparam int GridX = 32;
    localparam int GridY = 32;
    localparam int GridZ = 32;
    localparam int CoordW = 5;
    localparam int RowW = 2 * CoordW;
    localparam int Rows = GridX * GridY;
    localparam int CellW = 12;
    localparam int DistW = 33;
    localparam int QuotW = 31;
    localparam int RemW = 17;
    localparam int SdW = 32;
    localparam logic [23:0] MaxDistReset = 24'd4194304;

    localparam logic OpWrite = 1'b0;
    localparam logic OpCast = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [4:0]        write_x;
        logic [4:0]        write_y;
        logic [4:0]        write_z;
        logic              write_solid;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] origin_z;
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
        logic signed [15:0] heading_z;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [4:0] cell_z;
        logic [2:0] face;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WREAD,
        S_WMOD,
        S_DIV,
        S_MUL,
        S_STEP,
        S_TEST,
        S_DONE
    } t_state;

endpackage

FILE: sv/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// Top level of the voxel ray traversal block: occupancy memory, shared divider,
// multiplier and stepping sequencer. Depends on vrt_pkg.
//
// Usage: input transactions arrive on i_in_valid / o_in_stall carrying vrt_pkg::t_in.
// Opcode 0 writes one voxel's solid bit and produces no result.
// Opcode 1 casts a ray and produces one result transaction on o_out_valid /
// i_out_stall carrying vrt_pkg::t_out. A cast runs a restoring divider one quotient
// bit per cycle for each nonzero heading axis, skipping a zero axis, and follows each
// axis' division with a multiply. It then handles each voxel step in state S_STEP,
// which picks the axis and addresses the occupancy memory, and in state S_TEST, which
// tests the read bit. The block takes the next transaction once the result is in the
// output register.
// The max_dist register is written on i_cfg_valid / o_cfg_ready, always ready.
// After reset the block sweeps the 1024 rows of the occupancy memory to empty with
// o_in_stall high. A stalled result is held in the output register; a finished cast
// waits for it to drain before going idle.
module voxel_ray_traversal (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  vrt_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output vrt_pkg::t_out   o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [23:0]     i_cfg_data
);

    vrt_pkg::t_state r_state, n_state;
    vrt_pkg::t_in    r_item, n_item;
    logic [23:0]     r_max_dist;
    logic [vrt_pkg::RowW-1:0] r_clr, n_clr;

    logic [vrt_pkg::GridZ-1:0] r_mem [0:vrt_pkg::Rows-1];
    logic [vrt_pkg::GridZ-1:0] r_rd_data;
    logic [vrt_pkg::RowW-1:0]  rd_addr, wr_addr;
    logic [vrt_pkg::GridZ-1:0] wr_data;
    logic                      wr_en;

    logic [1:0]                r_axis, n_axis;
    logic [4:0]                r_bit, n_bit;
    logic [vrt_pkg::RemW-1:0]  r_rem, n_rem;
    logic [vrt_pkg::QuotW-1:0] r_quot, n_quot;
    logic [vrt_pkg::QuotW-1:0] r_delta [3];
    logic [vrt_pkg::QuotW-1:0] n_delta [3];
    logic [vrt_pkg::DistW-1:0] r_sd [3];
    logic [vrt_pkg::DistW-1:0] n_sd [3];
    logic signed [vrt_pkg::CellW-1:0] r_cell [3];
    logic signed [vrt_pkg::CellW-1:0] n_cell [3];
    logic [2:0]                r_act, n_act, r_neg, n_neg;
    logic [vrt_pkg::DistW-1:0] r_dist, n_dist;
    logic [1:0]                r_last, n_last;
    logic                      r_inb, n_inb;
    vrt_pkg::t_out             r_res, n_res, r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      in_acc, out_free;
    logic [15:0]               head_sel, mag;
    logic [15:0]               frac_sel;
    logic [16:0]               mul_a;
    logic [47:0]               prod;
    logic [vrt_pkg::RemW-1:0]  rem_sh;
    logic                      rem_ge;
    logic                      c10, c20, c21, any_act, best_ok;
    logic [1:0]                best;
    logic [vrt_pkg::DistW-1:0] sd_best;
    logic                      dist_ok, hit_now;
    logic signed [vrt_pkg::CellW-1:0] cell_new [3];

    assign in_acc = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != vrt_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    always_comb begin
        case (r_axis)
            2'd0: begin
                head_sel = r_item.heading_x;
                frac_sel = r_item.origin_x[15:0];
            end
            2'd1: begin
                head_sel = r_item.heading_y;
                frac_sel = r_item.origin_y[15:0];
            end
            default: begin
                head_sel = r_item.heading_z;
                frac_sel = r_item.origin_z[15:0];
            end
        endcase
        mag = head_sel[15] ? (16'd0 - head_sel) : head_sel;
        rem_sh = {r_rem[vrt_pkg::RemW-2:0], (r_bit == 5'd30)};
        rem_ge = (rem_sh >= {1'b0, mag});
        mul_a = head_sel[15] ? {1'b0, frac_sel} : (17'h10000 - {1'b0, frac_sel});
        prod = 48'(mul_a) * 48'(r_quot);
    end

    always_comb begin
        c10 = (r_sd[1] <= r_sd[0]);
        c20 = (r_sd[2] <= r_sd[0]);
        c21 = (r_sd[2] <= r_sd[1]);
        best = 2'd0;
        best_ok = r_act[0];
        if (r_act[1] && (!best_ok || c10)) begin
            best = 2'd1;
            best_ok = 1'b1;
        end
        if (r_act[2] && (!best_ok || ((best == 2'd1) ? c21 : c20))) begin
            best = 2'd2;
        end
        sd_best = r_sd[best];
        any_act = |r_act;
        dist_ok = (r_dist < {{(vrt_pkg::DistW-24){1'b0}}, r_max_dist});
        for (int a = 0; a < 3; a++) begin
            cell_new[a] = r_cell[a];
        end
        cell_new[best] = r_cell[best] + (r_neg[best] ? -12'sd1 : 12'sd1);
        hit_now = r_inb && r_rd_data[r_cell[2][vrt_pkg::CoordW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vrt_pkg::S_CLEAR: begin
                if (r_clr == {vrt_pkg::RowW{1'b1}}) begin
                    n_state = vrt_pkg::S_IDLE;
                end
            end
            vrt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.opcode == vrt_pkg::OpWrite) ? vrt_pkg::S_WREAD
                                                                : vrt_pkg::S_DIV;
                end
            end
            vrt_pkg::S_WREAD: n_state = vrt_pkg::S_WMOD;
            vrt_pkg::S_WMOD: n_state = vrt_pkg::S_IDLE;
            vrt_pkg::S_DIV: begin
                if (!r_act[r_axis] || r_bit == 5'd0) begin
                    n_state = vrt_pkg::S_MUL;
                end
            end
            vrt_pkg::S_MUL: begin
                if (r_axis == 2'd2) begin
                    n_state = any_act ? vrt_pkg::S_STEP : vrt_pkg::S_DONE;
                end else begin
                    n_state = vrt_pkg::S_DIV;
                end
            end
            vrt_pkg::S_STEP: n_state = dist_ok ? vrt_pkg::S_TEST : vrt_pkg::S_DONE;
            vrt_pkg::S_TEST: n_state = hit_now ? vrt_pkg::S_DONE : vrt_pkg::S_STEP;
            vrt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = vrt_pkg::S_IDLE;
                end
            end
            default: n_state = vrt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_item = r_item;
        n_clr = r_clr;
        n_axis = r_axis;
        n_bit = r_bit;
        n_rem = r_rem;
        n_quot = r_quot;
        n_delta = r_delta;
        n_sd = r_sd;
        n_cell = r_cell;
        n_act = r_act;
        n_neg = r_neg;
        n_dist = r_dist;
        n_last = r_last;
        n_inb = r_inb;
        n_res = r_res;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr = {r_cell[0][vrt_pkg::CoordW-1:0], r_cell[1][vrt_pkg::CoordW-1:0]};
        wr_addr = r_clr;
        wr_data = '0;
        wr_en = 1'b0;
        case (r_state)
            vrt_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                n_clr = r_clr + 1'b1;
            end
            vrt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_item = i_in;
                    n_axis = 2'd0;
                    n_bit = 5'd30;
                    n_rem = '0;
                    n_quot = '0;
                    n_dist = '0;
                    n_res = '0;
                    n_act = {i_in.heading_z != 16'd0, i_in.heading_y != 16'd0,
                             i_in.heading_x != 16'd0};
                    n_neg = {i_in.heading_z[15], i_in.heading_y[15], i_in.heading_x[15]};
                    n_cell[0] = {{(vrt_pkg::CellW-8){i_in.origin_x[23]}}, i_in.origin_x[23:16]};
                    n_cell[1] = {{(vrt_pkg::CellW-8){i_in.origin_y[23]}}, i_in.origin_y[23:16]};
                    n_cell[2] = {{(vrt_pkg::CellW-8){i_in.origin_z[23]}}, i_in.origin_z[23:16]};
                end
            end
            vrt_pkg::S_WREAD: begin
                rd_addr = {r_item.write_x, r_item.write_y};
            end
            vrt_pkg::S_WMOD: begin
                wr_en = 1'b1;
                wr_addr = {r_item.write_x, r_item.write_y};
                wr_data = r_rd_data;
                wr_data[r_item.write_z] = r_item.write_solid;
            end
            vrt_pkg::S_DIV: begin
                if (!r_act[r_axis]) begin
                    n_quot = '0;
                end else begin
                    n_rem = rem_ge ? (rem_sh - {1'b0, mag}) : rem_sh;
                    n_quot = {r_quot[vrt_pkg::QuotW-2:0], rem_ge};
                    n_bit = r_bit - 5'd1;
                end
            end
            vrt_pkg::S_MUL: begin
                n_delta[r_axis] = r_quot;
                n_sd[r_axis] = {1'b0, prod[47:16]};
                n_axis = r_axis + 2'd1;
                n_bit = 5'd30;
                n_rem = '0;
                n_quot = '0;
            end
            vrt_pkg::S_STEP: begin
                if (dist_ok) begin
                    n_dist = sd_best;
                    n_sd[best] = sd_best + vrt_pkg::DistW'(r_delta[best]);
                    n_cell = cell_new;
                    n_last = best;
                    n_inb = (cell_new[0][vrt_pkg::CellW-1:vrt_pkg::CoordW] == '0) &&
                            (cell_new[1][vrt_pkg::CellW-1:vrt_pkg::CoordW] == '0) &&
                            (cell_new[2][vrt_pkg::CellW-1:vrt_pkg::CoordW] == '0);
                    rd_addr = {cell_new[0][vrt_pkg::CoordW-1:0],
                               cell_new[1][vrt_pkg::CoordW-1:0]};
                end
            end
            vrt_pkg::S_TEST: begin
                if (hit_now) begin
                    n_res.hit = 1'b1;
                    n_res.cell_x = r_cell[0][vrt_pkg::CoordW-1:0];
                    n_res.cell_y = r_cell[1][vrt_pkg::CoordW-1:0];
                    n_res.cell_z = r_cell[2][vrt_pkg::CoordW-1:0];
                    n_res.face = {r_last, r_neg[r_last]};
                end
            end
            vrt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrt_pkg::S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
            r_max_dist <= vrt_pkg::MaxDistReset;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_dist <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_axis <= n_axis;
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_quot <= n_quot;
        r_delta <= n_delta;
        r_sd <= n_sd;
        r_cell <= n_cell;
        r_act <= n_act;
        r_neg <= n_neg;
        r_dist <= n_dist;
        r_last <= n_last;
        r_inb <= n_inb;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

FILE: sv/vrt_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the voxel ray traversal block, bound to the top level.
// Depends on vrt_pkg and voxel_ray_traversal.
module vrt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input vrt_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("Stalled result transaction changed.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.hit |-> o_out.cell_x == 5'd0 && o_out.cell_y == 5'd0 &&
        o_out.cell_z == 5'd0 && o_out.face == 3'd0)
        else $error("Miss result carries nonzero fields.");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.face <= 3'd5)
        else $error("Face code out of range.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input taken before the occupancy clear.");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
